@@ sv/tmhq_pkg.sv @@
`timescale 1ns / 1ps

package tmhq_pkg;

   localparam int KIND_W       = 2;
   localparam int NOW_W        = 48;
   localparam int TIMEOUT_W    = 31;
   localparam int ID_W         = 32;
   localparam int WAIT_W       = 32;
   localparam int EXP_W        = NOW_W + 1;
   localparam int CAPACITY_DEF = 32;
   localparam int MAX_FIRE     = 32;
   localparam int FIRE_W       = $clog2(MAX_FIRE + 1);

   localparam logic [EXP_W-1:0] WAIT_MAX = EXP_W'(64'h7FFF_FFFF);

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD    = 2'd0,
      KIND_CANCEL = 2'd1,
      KIND_TICK   = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      RK_ID     = 2'd0,
      RK_CANCEL = 2'd1,
      RK_FIRE   = 2'd2,
      RK_WAIT   = 2'd3
   } rsp_kind_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_CANCEL,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      logic             valid;
      logic             cancelled;
      logic [ID_W-1:0]  id;
      logic [EXP_W-1:0] expiry;
   } entry_type;

   typedef struct packed {
      cell_op_type      op;
      logic [ID_W-1:0]  id;
      logic [EXP_W-1:0] expiry;
   } cell_ctrl_type;

   typedef struct packed {
      rsp_kind_type             result_kind;
      logic [ID_W-1:0]          timer_id;
      logic signed [WAIT_W-1:0] wait_ms;
      logic                     full_error;
      logic                     last;
   } rsp_type;

endpackage

@@ sv/tmhq_req_if.sv @@
`timescale 1ns / 1ps

interface tmhq_req_if;
   import tmhq_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [NOW_W-1:0]     now_ms;
   logic [TIMEOUT_W-1:0] timeout_ms;
   logic [ID_W-1:0]      cancel_id;

   modport source (output valid, output kind, output now_ms, output timeout_ms,
                   output cancel_id, input ready);
   modport sink (input valid, input kind, input now_ms, input timeout_ms,
                 input cancel_id, output ready);
endinterface

@@ sv/tmhq_rsp_if.sv @@
`timescale 1ns / 1ps

interface tmhq_rsp_if;
   import tmhq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [1:0]               result_kind;
   logic [ID_W-1:0]          timer_id;
   logic signed [WAIT_W-1:0] wait_ms;
   logic                     full_error;
   logic                     last;

   modport source (output valid, output result_kind, output timer_id, output wait_ms,
                   output full_error, output last, input ready);
   modport sink (input valid, input result_kind, input timer_id, input wait_ms,
                 input full_error, input last, output ready);
endinterface

@@ sv/tmhq_cell.sv @@
`timescale 1ns / 1ps

module tmhq_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  tmhq_pkg::cell_ctrl_type ctrl,
   input  tmhq_pkg::entry_type     prev_entry,
   input  logic                    prev_gt,
   input  tmhq_pkg::entry_type     next_entry,
   output tmhq_pkg::entry_type     entry,
   output logic                    gt
);
   import tmhq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // An empty cell counts as later than any new timer, so the queue stays sorted
   // by expiry with equal expiries kept in insertion order.
   assign gt = !entry_ff.valid || (entry_ff.expiry > ctrl.expiry);

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (gt) begin
               if (prev_gt) begin
                  entry_in = prev_entry;
               end else begin
                  entry_in.valid     = 1'b1;
                  entry_in.cancelled = 1'b0;
                  entry_in.id        = ctrl.id;
                  entry_in.expiry    = ctrl.expiry;
               end
            end
         end
         CELL_CANCEL: begin
            if (entry_ff.valid && (entry_ff.id == ctrl.id)) begin
               entry_in.cancelled = 1'b1;
            end
         end
         CELL_SHIFT: begin
            entry_in = next_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

@@ sv/timer_min_heap_queue.sv @@
`timescale 1ns / 1ps
// An add or cancel result is loaded into the output register from the add or cancel state
// that follows acceptance. A tick removes due timers from the head cell one at a time, with
// a fire result for each one not cancelled, then a wait result. One transaction at a time;
// the next can be accepted in the cycle after the last result is loaded.
// Results wait in an output register until taken and stall only the step that needs it.
// Synchronous reset empties the queue and sets the next identifier to zero at once.

module timer_min_heap_queue #(
   parameter int CAPACITY = tmhq_pkg::CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   tmhq_req_if.sink          req_ch,
   tmhq_rsp_if.source        rsp_ch
);
   import tmhq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_CANCEL,
      ST_TICK
   } state_type;

   state_type           state_ff, state_in;
   logic [EXP_W-1:0]    exp_ff, exp_in;
   logic [NOW_W-1:0]    now_ff, now_in;
   logic [ID_W-1:0]     cid_ff, cid_in;
   logic [ID_W-1:0]     next_id_ff, next_id_in;
   logic [FIRE_W-1:0]   fire_cnt_ff, fire_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   cell_ctrl_type       ctrl;
   entry_type           cell_q   [CAPACITY];
   entry_type           prev_ent [CAPACITY];
   entry_type           next_ent [CAPACITY];
   logic [CAPACITY-1:0] cell_gt;
   logic [CAPACITY-1:0] prev_gt;
   logic [CAPACITY-1:0] cell_valid;

   logic                accept;
   logic                out_free;
   logic                full;
   entry_type           head;
   logic [EXP_W-1:0]    now_ext;
   logic                head_due;
   logic [EXP_W-1:0]    diff;
   logic [WAIT_W-1:0]   wait_val;

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         prev_ent[i]   = (i == 0) ? '0 : cell_q[(i == 0) ? 0 : i - 1];
         prev_gt[i]    = (i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1];
         next_ent[i]   = (i == CAPACITY - 1) ? '0 : cell_q[(i == CAPACITY - 1) ? i : i + 1];
         cell_valid[i] = cell_q[i].valid;
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      tmhq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_entry (prev_ent[g]),
         .prev_gt    (prev_gt[g]),
         .next_entry (next_ent[g]),
         .entry      (cell_q[g]),
         .gt         (cell_gt[g])
      );
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign full         = cell_q[CAPACITY-1].valid;

   assign head     = cell_q[0];
   assign now_ext  = EXP_W'(now_ff);
   assign head_due = head.valid && (head.expiry <= now_ext);
   assign diff     = head.expiry - now_ext;

   always_comb begin
      if (!head.valid) begin
         wait_val = '1;
      end else if (head_due) begin
         wait_val = '0;
      end else if (diff > WAIT_MAX) begin
         wait_val = WAIT_W'(WAIT_MAX);
      end else begin
         wait_val = WAIT_W'(diff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      exp_in       = exp_ff;
      now_in       = now_ff;
      cid_in       = cid_ff;
      next_id_in   = next_id_ff;
      fire_cnt_in  = fire_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_in       = rsp_ff;
      ctrl.op      = CELL_HOLD;
      ctrl.id      = (state_ff == ST_ADD) ? next_id_ff : cid_ff;
      ctrl.expiry  = exp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               exp_in      = EXP_W'(req_ch.now_ms) + EXP_W'(req_ch.timeout_ms);
               now_in      = req_ch.now_ms;
               cid_in      = req_ch.cancel_id;
               fire_cnt_in = '0;
               case (req_ch.kind)
                  KIND_ADD:    state_in = ST_ADD;
                  KIND_CANCEL: state_in = ST_CANCEL;
                  KIND_TICK:   state_in = ST_TICK;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.result_kind = RK_ID;
               rsp_in.wait_ms     = '0;
               rsp_in.last        = 1'b1;
               if (full) begin
                  rsp_in.timer_id   = '0;
                  rsp_in.full_error = 1'b1;
               end else begin
                  ctrl.op           = CELL_INSERT;
                  rsp_in.timer_id   = next_id_ff;
                  rsp_in.full_error = 1'b0;
                  next_id_in        = next_id_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_CANCEL: begin
            if (out_free) begin
               ctrl.op            = CELL_CANCEL;
               rsp_valid_in       = 1'b1;
               rsp_in.result_kind = RK_CANCEL;
               rsp_in.timer_id    = cid_ff;
               rsp_in.wait_ms     = '0;
               rsp_in.full_error  = 1'b0;
               rsp_in.last        = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         ST_TICK: begin
            if (head_due && head.cancelled) begin
               ctrl.op = CELL_SHIFT;
            end else if (head_due && (fire_cnt_ff < FIRE_W'(MAX_FIRE))) begin
               if (out_free) begin
                  ctrl.op            = CELL_SHIFT;
                  rsp_valid_in       = 1'b1;
                  rsp_in.result_kind = RK_FIRE;
                  rsp_in.timer_id    = head.id;
                  rsp_in.wait_ms     = '0;
                  rsp_in.full_error  = 1'b0;
                  rsp_in.last        = 1'b0;
                  fire_cnt_in        = fire_cnt_ff + 1'b1;
               end
            end else if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.result_kind = RK_WAIT;
               rsp_in.timer_id    = '0;
               rsp_in.wait_ms     = wait_val;
               rsp_in.full_error  = 1'b0;
               rsp_in.last        = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      exp_ff <= exp_in;
      now_ff <= now_in;
      cid_ff <= cid_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         next_id_ff   <= '0;
         fire_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_id_ff   <= next_id_in;
         fire_cnt_ff  <= fire_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_kind = rsp_ff.result_kind;
   assign rsp_ch.timer_id    = rsp_ff.timer_id;
   assign rsp_ch.wait_ms     = rsp_ff.wait_ms;
   assign rsp_ch.full_error  = rsp_ff.full_error;
   assign rsp_ch.last        = rsp_ff.last;

`ifndef SYNTH
   // Occupied cells always form an unbroken run from the head.
   a_cells_packed: assert property (@(posedge clock) disable iff (reset)
      (cell_valid & (cell_valid + 1'b1)) == '0)
      else $error("queue cells are not packed from the head");

   // The head holds an expiry no later than its neighbour.
   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      cell_q[1].valid |-> (cell_q[0].expiry <= cell_q[1].expiry))
      else $error("queue is out of expiry order at the head");

   // A tick never fires more than the per-tick limit.
   a_fire_limit: assert property (@(posedge clock) disable iff (reset)
      fire_cnt_ff <= FIRE_W'(MAX_FIRE))
      else $error("fire count exceeds the per-tick limit");

   // A refused add leaves the identifier counter untouched.
   a_full_keeps_id: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD && out_free && full) |=> $stable(next_id_ff))
      else $error("identifier advanced on a refused add");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import tmhq_pkg::*;

   localparam logic [KIND_W-1:0]    KIND_UNUSED  = 2'd3;
   localparam logic [NOW_W-1:0]     NOW_MAX      = '1;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX  = '1;
   localparam int                   STALL_LIMIT  = 4000;
   localparam int                   DRAIN_CYCLES = 40;
   localparam int                   HOLD_CYCLES  = 300;

   typedef struct {
      logic [EXP_W-1:0] expiry;
      logic [ID_W-1:0]  id;
      bit               cancelled;
   } timer_entry_type;

   logic clock = 1'b0;
   logic reset;

   tmhq_req_if req_bus ();
   tmhq_rsp_if rsp_bus ();

   timer_min_heap_queue i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   timer_entry_type  queued_timers[$];
   rsp_type          awaited_rsps[$];
   logic [ID_W-1:0]  next_timer_id;
   logic [NOW_W-1:0] cur_ms;
   int               send_idle_pct;
   int               recv_stall_pct;
   int               hold_left;
   int               n_requests;
   int               n_ticks;
   int               n_checked;
   int               n_fired;
   int               n_refused;
   int               n_errors;
   int               idle_count;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void expect_rsp(rsp_kind_type kind, logic [ID_W-1:0] id,
                                      logic [WAIT_W-1:0] wait_val, logic full, logic fin);
      rsp_type r;
      r.result_kind = kind;
      r.timer_id    = id;
      r.wait_ms     = wait_val;
      r.full_error  = full;
      r.last        = fin;
      awaited_rsps  = {awaited_rsps, r};
   endfunction

   // Earliest expiry wins; among equal expiries the oldest entry is kept.
   function automatic int earliest_timer();
      int best;
      best = 0;
      for (int i = 1; i < queued_timers.size(); i++)
         if (queued_timers[i].expiry < queued_timers[best].expiry) best = i;
      return best;
   endfunction

   function automatic void predict_timer_outcome(logic [KIND_W-1:0] kind,
                                                 logic [NOW_W-1:0] now,
                                                 logic [TIMEOUT_W-1:0] tmo,
                                                 logic [ID_W-1:0] cid);
      int               b;
      int               fired;
      logic [EXP_W-1:0] now_x;
      logic [EXP_W-1:0] gap;
      timer_entry_type  t;
      now_x = {1'b0, now};
      case (kind)
         KIND_ADD: begin
            if (queued_timers.size() >= CAPACITY_DEF) begin
               expect_rsp(RK_ID, '0, '0, 1'b1, 1'b1);
               n_refused++;
            end else begin
               t.expiry      = now_x + EXP_W'(tmo);
               t.id          = next_timer_id;
               t.cancelled   = 1'b0;
               queued_timers = {queued_timers, t};
               expect_rsp(RK_ID, next_timer_id, '0, 1'b0, 1'b1);
               next_timer_id++;
            end
         end
         KIND_CANCEL: begin
            foreach (queued_timers[i])
               if (queued_timers[i].id == cid) queued_timers[i].cancelled = 1'b1;
            expect_rsp(RK_CANCEL, cid, '0, 1'b0, 1'b1);
         end
         KIND_TICK: begin
            fired = 0;
            while (queued_timers.size() > 0) begin
               b = earliest_timer();
               if (queued_timers[b].expiry > now_x) break;
               if (!queued_timers[b].cancelled) begin
                  if (fired >= MAX_FIRE) break;
                  expect_rsp(RK_FIRE, queued_timers[b].id, '0, 1'b0, 1'b0);
                  fired++;
               end
               queued_timers.delete(b);
            end
            n_fired += fired;
            if (queued_timers.size() == 0) begin
               expect_rsp(RK_WAIT, '0, '1, 1'b0, 1'b1);
            end else begin
               b = earliest_timer();
               if (queued_timers[b].expiry <= now_x) begin
                  gap = '0;
               end else begin
                  gap = queued_timers[b].expiry - now_x;
                  if (gap > WAIT_MAX) gap = WAIT_MAX;
               end
               expect_rsp(RK_WAIT, '0, gap[WAIT_W-1:0], 1'b0, 1'b1);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         n_errors++;
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endfunction

   task automatic send_request(input logic [KIND_W-1:0] kind, input logic [NOW_W-1:0] now,
                               input logic [TIMEOUT_W-1:0] tmo, input logic [ID_W-1:0] cid);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.kind       <= kind;
      req_bus.now_ms     <= now;
      req_bus.timeout_ms <= tmo;
      req_bus.cancel_id  <= cid;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_timer_outcome(kind, now, tmo, cid);
      n_requests++;
      if (kind == KIND_TICK) n_ticks++;
   endtask

   task automatic test_directed();
      send_request(KIND_TICK, '0, '0, '0);
      send_request(KIND_ADD, '0, '0, '0);
      send_request(KIND_ADD, 48'd100, 31'd50, '0);
      send_request(KIND_ADD, 48'd100, 31'd50, '1);
      send_request(KIND_ADD, 48'd1000, TIMEOUT_MAX, '0);
      send_request(KIND_TICK, '0, '0, '0);
      send_request(KIND_CANCEL, NOW_MAX, TIMEOUT_MAX, '0);
      send_request(KIND_CANCEL, '0, '0, 32'd1);
      send_request(KIND_CANCEL, '0, '0, 32'd1);
      send_request(KIND_CANCEL, '0, '0, '1);
      send_request(KIND_TICK, '0, '0, '0);
      send_request(KIND_TICK, 48'd150, '0, '0);
      send_request(KIND_UNUSED, NOW_MAX, TIMEOUT_MAX, '1);
      send_request(KIND_ADD, NOW_MAX, TIMEOUT_MAX, '0);
      send_request(KIND_TICK, NOW_MAX, '0, '0);
      send_request(KIND_TICK, '0, '0, '0);
      send_request(KIND_ADD, 48'd5, 31'd3, '0);
      send_request(KIND_TICK, 48'd6, '0, '0);
      send_request(KIND_TICK, NOW_MAX, '0, '0);
      cur_ms = 48'd2000;
   endtask

   // The timers added here share one expiry, so the tick must fire them in insertion order.
   task automatic test_queue_full();
      while (queued_timers.size() < CAPACITY_DEF)
         send_request(KIND_ADD, cur_ms, 31'd25, '0);
      send_request(KIND_ADD, cur_ms, 31'd25, '0);
      send_request(KIND_ADD, cur_ms, '0, '0);
      send_request(KIND_CANCEL, '0, '0, next_timer_id - 32'd3);
      send_request(KIND_TICK, cur_ms + 48'd25, '0, '0);
      cur_ms += 48'd30;
   endtask

   task automatic test_output_backpressure();
      int keep_idle;
      keep_idle     = send_idle_pct;
      send_idle_pct = 0;
      hold_left     = HOLD_CYCLES;
      for (int i = 0; i < 16; i++)
         send_request(KIND_ADD, cur_ms, TIMEOUT_W'($urandom_range(60)), '0);
      send_request(KIND_TICK, cur_ms + 48'd100, '0, '0);
      cur_ms += 48'd100;
      send_idle_pct = keep_idle;
   endtask

   task automatic send_random_request(output bit counted);
      int                   pick;
      logic [TIMEOUT_W-1:0] tmo;
      logic [ID_W-1:0]      cid;
      pick = $urandom_range(99);
      if ($urandom_range(99) < 3) cur_ms = NOW_W'({$urandom, $urandom});
      else cur_ms += NOW_W'($urandom_range(40));
      tmo = ($urandom_range(99) < 8) ? TIMEOUT_W'($urandom) : TIMEOUT_W'($urandom_range(150));
      cid = ($urandom_range(99) < 10) ? ID_W'($urandom)
                                       : next_timer_id - ID_W'($urandom_range(1, 40));
      counted = 1'b1;
      if (pick < 45) begin
         send_request(KIND_ADD, cur_ms, tmo, ID_W'($urandom));
      end else if (pick < 65) begin
         send_request(KIND_CANCEL, NOW_W'({$urandom, $urandom}), TIMEOUT_W'($urandom), cid);
      end else if (pick < 95) begin
         send_request(KIND_TICK, cur_ms, TIMEOUT_W'($urandom), ID_W'($urandom));
      end else begin
         send_request(KIND_UNUSED, NOW_W'({$urandom, $urandom}), TIMEOUT_W'($urandom),
                      ID_W'($urandom));
         counted = 1'b0;
      end
   endtask

   task automatic run_random_phase(input int n_items);
      int  done;
      bit  counted;
      done = 0;
      while (done < n_items) begin
         send_random_request(counted);
         if (counted) done++;
      end
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         n_checked++;
         if (awaited_rsps.size() == 0) begin
            n_errors++;
            $display("%0t ns: unexpected result, expected none, actual kind %0d id 0x%0h",
                     $time, rsp_bus.result_kind, rsp_bus.timer_id);
         end else begin
            want = awaited_rsps.pop_front();
            compare_field("result_kind", 64'(want.result_kind), 64'(rsp_bus.result_kind));
            compare_field("timer_id", 64'(want.timer_id), 64'(rsp_bus.timer_id));
            compare_field("wait_ms", 64'(want.wait_ms), 64'(rsp_bus.wait_ms));
            compare_field("full_error", 64'(want.full_error), 64'(rsp_bus.full_error));
            compare_field("last", 64'(want.last), 64'(rsp_bus.last));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= STALL_LIMIT) begin
         $display("%0t ns: no transaction for %0d cycles, %0d results outstanding",
                  $time, STALL_LIMIT, awaited_rsps.size());
         $display("timer_min_heap_queue test failed");
         $finish;
      end
   end

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.kind       <= KIND_ADD;
      req_bus.now_ms     <= '0;
      req_bus.timeout_ms <= '0;
      req_bus.cancel_id  <= '0;
      hold_left          = 0;
      send_idle_pct      = 14;
      recv_stall_pct     = 53;
      next_timer_id      = '0;
      cur_ms             = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_queue_full();
      run_random_phase(70);

      send_idle_pct  = 53;
      recv_stall_pct = 14;
      test_output_backpressure();
      run_random_phase(70);

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random_phase(60);

      req_bus.valid <= 1'b0;
      while (awaited_rsps.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests (%0d ticks); checked %0d results, %0d firings, %0d refusals.",
               n_requests, n_ticks, n_checked, n_fired, n_refused);
      $display("Idle patterns on both sides, a full queue and a %0d-cycle output hold were run.",
               HOLD_CYCLES);
      if (n_errors == 0 && awaited_rsps.size() == 0)
         $display("timer_min_heap_queue test passed");
      else
         $display("timer_min_heap_queue test failed");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/tmhq_pkg.sv
sv/tmhq_req_if.sv
sv/tmhq_rsp_if.sv
sv/tmhq_cell.sv
sv/timer_min_heap_queue.sv
tb/sv/tb_top.sv
